// ===== design/assert_macros.svh =====
// Assertion macros shared by the timebase RTL.
// Needs nothing else; pull in with a plain include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define CTB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CTB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ctb_pkg.sv =====
// Shared types, constants and helpers of the cascaded timebase.
// No dependencies; imported by the request channel interface and all modules.
`default_nettype none

package ctb_pkg;

   localparam int unsigned TenthsWrap     = 10;
   localparam int unsigned HundredsWrap   = 10;
   localparam int unsigned SecondsWrap    = 60;
   localparam logic [7:0]  MaxRunReset    = 8'd60;

   localparam int unsigned FlagCount      = 6;
   localparam int unsigned Flag10ms       = 0;
   localparam int unsigned Flag100ms      = 1;
   localparam int unsigned Flag300ms      = 2;
   localparam int unsigned Flag1s         = 3;
   localparam int unsigned Flag1min       = 4;
   localparam int unsigned FlagOvertime   = 5;

   typedef enum logic [1:0] {
      MODE_BASE_TICK   = 2'd0,
      MODE_BUZZER_TICK = 2'd1,
      MODE_HOST        = 2'd2
   } ctb_mode_type;

   typedef struct packed {
      logic [1:0]           mode;
      logic [FlagCount-1:0] clear_mask;
      logic                 beep_once_set;
      logic                 beep_interval_level;
   } ctb_req_type;

   typedef struct packed {
      logic [FlagCount-1:0] flags;
      logic                 watchdog_feed;
      logic                 converter_off;
      logic                 buzzer_out;
      logic [5:0]           seconds_now;
      logic [8:0]           minutes_now;
   } ctb_rsp_type;

   typedef struct packed {
      logic [3:0]           tenths;
      logic [3:0]           hundreds;
      logic [5:0]           seconds;
      logic [8:0]           minutes;
      logic [FlagCount-1:0] flags;
      logic                 beep_once;
      logic                 beep_interval;
      logic                 buzzer;
      logic                 silence;
   } ctb_state_type;

   // True for 0, 3, 6, 9, 12 and 15.
   function automatic logic is_mult3(input logic [3:0] value);
      logic result;
      unique case (value)
         4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: result = 1'b1;
         default:                              result = 1'b0;
      endcase
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== design/ctb_if.sv =====
// Valid/ready channel interfaces for the timebase request and response.
// Depends on ctb_pkg for the field widths.
`default_nettype none

interface ctb_req_if
   import ctb_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           mode;
   logic [FlagCount-1:0] clear_mask;
   logic                 beep_once_set;
   logic                 beep_interval_level;

   modport source (output valid, output mode, output clear_mask,
                   output beep_once_set, output beep_interval_level, input ready);
   modport sink   (input valid, input mode, input clear_mask,
                   input beep_once_set, input beep_interval_level, output ready);
endinterface

interface ctb_rsp_if;
   logic       valid;
   logic       ready;
   logic       flag_10ms;
   logic       flag_100ms;
   logic       flag_300ms;
   logic       flag_1s;
   logic       flag_1min;
   logic       overtime_flag;
   logic       watchdog_feed;
   logic       converter_off;
   logic       buzzer_out;
   logic [5:0] seconds_now;
   logic [8:0] minutes_now;

   modport source (output valid, output flag_10ms, output flag_100ms, output flag_300ms,
                   output flag_1s, output flag_1min, output overtime_flag,
                   output watchdog_feed, output converter_off, output buzzer_out,
                   output seconds_now, output minutes_now, input ready);
   modport sink   (input valid, input flag_10ms, input flag_100ms, input flag_300ms,
                   input flag_1s, input flag_1min, input overtime_flag,
                   input watchdog_feed, input converter_off, input buzzer_out,
                   input seconds_now, input minutes_now, output ready);
endinterface

`default_nettype wire

// ===== design/ctb_step.sv =====
// Single-pass next-state and response logic for one timebase item.
// Depends on ctb_pkg.
`default_nettype none

module ctb_step
   import ctb_pkg::*;
(
   input  ctb_state_type cur_state,
   input  ctb_req_type   req,
   input  logic [7:0]    max_run_minutes,
   output ctb_state_type nxt_state,
   output ctb_rsp_type   rsp
);

   logic       feed;
   logic       off;
   logic [3:0] tenths_inc;
   logic [3:0] hundreds_inc;
   logic [5:0] seconds_inc;
   logic [8:0] minutes_inc;

   assign tenths_inc   = cur_state.tenths + 4'd1;
   assign seconds_inc  = cur_state.seconds + 6'd1;
   assign minutes_inc  = cur_state.minutes + 9'd1;

   always_comb begin
      nxt_state    = cur_state;
      feed         = 1'b0;
      off          = 1'b0;
      hundreds_inc = cur_state.hundreds;
      unique case (req.mode)
         MODE_BASE_TICK: begin
            nxt_state.flags[Flag10ms] = 1'b1;
            nxt_state.tenths          = tenths_inc;
            if (tenths_inc >= 4'(TenthsWrap)) begin
               nxt_state.tenths           = 4'd0;
               nxt_state.flags[Flag100ms] = 1'b1;
               hundreds_inc               = cur_state.hundreds + 4'd1;
            end
            nxt_state.hundreds = hundreds_inc;
            // test the count after the carry and before its wrap
            if (is_mult3(hundreds_inc)) begin
               nxt_state.flags[Flag300ms] = 1'b1;
               feed                       = 1'b1;
            end
            if (hundreds_inc >= 4'(HundredsWrap)) begin
               nxt_state.hundreds      = 4'd0;
               nxt_state.flags[Flag1s] = 1'b1;
               nxt_state.seconds       = seconds_inc;
               if (seconds_inc >= 6'(SecondsWrap)) begin
                  nxt_state.seconds         = 6'd0;
                  nxt_state.flags[Flag1min] = 1'b1;
                  nxt_state.minutes         = minutes_inc;
                  if (minutes_inc > {1'b0, max_run_minutes}) begin
                     nxt_state.minutes             = 9'd0;
                     nxt_state.flags[FlagOvertime] = 1'b1;
                     off                           = 1'b1;
                  end
               end
            end
         end
         MODE_BUZZER_TICK: begin
            if (cur_state.beep_once) begin
               if (!is_mult3(cur_state.hundreds)) begin
                  nxt_state.buzzer = ~cur_state.buzzer;
               end else begin
                  nxt_state.buzzer    = 1'b0;
                  nxt_state.beep_once = 1'b0;
               end
            end
            if (cur_state.beep_interval) begin
               nxt_state.silence = 1'b1;
               // beep during even seconds, quiet during odd ones
               if (!cur_state.seconds[0]) begin
                  nxt_state.buzzer = ~nxt_state.buzzer;
               end else begin
                  nxt_state.buzzer = 1'b0;
               end
            end else if (cur_state.silence) begin
               nxt_state.buzzer  = 1'b0;
               nxt_state.silence = 1'b0;
            end
         end
         MODE_HOST: begin
            nxt_state.flags = cur_state.flags & ~req.clear_mask;
            if (req.beep_once_set) begin
               nxt_state.beep_once = 1'b1;
            end
            nxt_state.beep_interval = req.beep_interval_level;
         end
         default: begin
            // unused code: hold all state
         end
      endcase
   end

   assign rsp.flags         = nxt_state.flags;
   assign rsp.watchdog_feed = feed;
   assign rsp.converter_off = off;
   assign rsp.buzzer_out    = nxt_state.buzzer;
   assign rsp.seconds_now   = nxt_state.seconds;
   assign rsp.minutes_now   = nxt_state.minutes;

endmodule

`default_nettype wire

// ===== design/cascaded_timebase_with_run_limit.sv =====
// Cascaded 10 ms timebase with run-time limit and buzzer sequencing: top level.
// Depends on ctb_pkg, ctb_if, ctb_step and assert_macros.svh.
//
// Every request (base tick, buzzer tick or host item) yields exactly one response.
// A request is captured in an input register and processed in one pass of the step
// logic into the response register, so the block takes one item per clock cycle
// unless the response register is stalled. A response is presented from the response
// register and transfers at the first edge at which the response side is ready. The
// input register holds an item while the response register is stalled, so a new
// request is still taken as long as that slot is free. Mode 3 is answered with the
// current status and both pulses low. The run limit (csr_wr_data) resets to 60
// minutes and should be written while no item is in flight.
`default_nettype none

`include "assert_macros.svh"

module cascaded_timebase_with_run_limit
   import ctb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ctb_req_if.sink    req_if,
   ctb_rsp_if.source  rsp_if,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic          in_valid_ff;
   ctb_req_type   in_ff;
   logic          rsp_valid_ff;
   ctb_rsp_type   rsp_ff;
   ctb_state_type state_ff;
   logic [7:0]    max_run_ff;

   ctb_req_type   req_in;
   ctb_state_type state_in;
   ctb_rsp_type   rsp_in;
   logic          advance;
   logic          req_xfer;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_xfer     = req_if.valid && req_if.ready;

   assign req_in.mode                = req_if.mode;
   assign req_in.clear_mask          = req_if.clear_mask;
   assign req_in.beep_once_set       = req_if.beep_once_set;
   assign req_in.beep_interval_level = req_if.beep_interval_level;

   ctb_step u_step (
      .cur_state       (state_ff),
      .req             (in_ff),
      .max_run_minutes (max_run_ff),
      .nxt_state       (state_in),
      .rsp             (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_run_ff   <= MaxRunReset;
         state_ff     <= '{tenths: 4'd0, hundreds: 4'd0, seconds: 6'd0, minutes: 9'd0,
                           flags: '0, beep_once: 1'b0, beep_interval: 1'b0,
                           buzzer: 1'b0, silence: 1'b1};
      end else begin
         if (req_xfer) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            max_run_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.flag_10ms     = rsp_ff.flags[Flag10ms];
   assign rsp_if.flag_100ms    = rsp_ff.flags[Flag100ms];
   assign rsp_if.flag_300ms    = rsp_ff.flags[Flag300ms];
   assign rsp_if.flag_1s       = rsp_ff.flags[Flag1s];
   assign rsp_if.flag_1min     = rsp_ff.flags[Flag1min];
   assign rsp_if.overtime_flag = rsp_ff.flags[FlagOvertime];
   assign rsp_if.watchdog_feed = rsp_ff.watchdog_feed;
   assign rsp_if.converter_off = rsp_ff.converter_off;
   assign rsp_if.buzzer_out    = rsp_ff.buzzer_out;
   assign rsp_if.seconds_now   = rsp_ff.seconds_now;
   assign rsp_if.minutes_now   = rsp_ff.minutes_now;

   `CTB_ASSERT_ALWAYS(a_reset_empties, clock,
      reset |=> !rsp_valid_ff && !in_valid_ff,
      "pipeline not empty after reset")
   `CTB_ASSERT(a_hold_input, clock, reset,
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff),
      "stalled input item lost")
   `CTB_ASSERT(a_off_sets_overtime, clock, reset,
      rsp_valid_ff && rsp_ff.converter_off |->
         rsp_ff.flags[FlagOvertime] && rsp_ff.minutes_now == 9'd0,
      "converter off without overtime")
   `CTB_ASSERT(a_feed_sets_flag, clock, reset,
      rsp_valid_ff && rsp_ff.watchdog_feed |->
         rsp_ff.flags[Flag300ms] && rsp_ff.flags[Flag10ms],
      "watchdog feed without 300 ms flag")
   `CTB_ASSERT(a_counts_in_range, clock, reset,
      state_ff.seconds < 6'd60 && state_ff.tenths < 4'd10 && state_ff.minutes <= 9'd256,
      "timebase count out of range")

endmodule

`default_nettype wire
